// ----- rtl/qmp_pkg.sv -----
`timescale 1ns / 1ps
// qmp_pkg: shared widths and defaults for the quicksort block.
// No dependencies; used by quicksort_middle_pivot, qmp_checker and the testbench.
package qmp_pkg;

  localparam int VAL_W         = 32;  // element width, signed
  localparam int MAX_ITEMS_DEF = 64;  // default store depth

endpackage

// ----- rtl/quicksort_middle_pivot.sv -----
`timescale 1ns / 1ps
// Quicksort block, Hoare partition around the middle element, range stack in RAM.
// Input beats load back to back while idle; after the last beat the sort steps through its
//   compare, exchange and range states, then results drain one read at a time (one-read store).
// Throughput: one set at a time; in_stall stays high from the last input beat until
//   the final result beat sits in the output register.
// Reset (rst_n, synchronous): clears sequencer, counts and output valid; stores not cleared.
module quicksort_middle_pivot #(
  parameter int MAX_ITEMS = qmp_pkg::MAX_ITEMS_DEF  // 2..64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [qmp_pkg::VAL_W-1:0] in_item_value,
  input  logic                           in_last_item,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [qmp_pkg::VAL_W-1:0] out_sorted_value,
  output logic                           out_end_of_run,
  output logic                           out_overflow
);

  // IW: element index, CW: counts up to MAX_ITEMS, SW: signed scan index that can
  // step one past either end of a range (-1 .. MAX_ITEMS).
  localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = IW + 2;
  localparam int RW = 2 * IW;  // stack entry: {hi, lo}

  typedef logic signed [SW-1:0]            sidx_t;
  typedef logic signed [qmp_pkg::VAL_W-1:0] val_t;

  typedef enum logic [3:0] {
    ST_IDLE,    // loading beats
    ST_POP,     // pop next range or finish
    ST_PIVA,    // range fields valid, fetch middle element
    ST_PIVB,    // latch pivot
    ST_SLREQ,   // left scan: fetch store[l]
    ST_SLCHK,   // left scan: compare with pivot
    ST_SRREQ,   // right scan: fetch store[r]
    ST_SRCHK,   // right scan: compare with pivot
    ST_SWAP1,   // write store[l]
    ST_SWAP2,   // write store[r], step both
    ST_LOOP,    // outer partition loop test
    ST_PUSHLO,  // push left part
    ST_PUSHHI,  // push right part
    ST_EMREQ,   // fetch store[k]
    ST_EMWAIT   // hand store[k] to the output register
  } state_t;

  // ---------------------------------------------------------------------------
  // Memories: element store and range stack, one write and one registered read
  // ---------------------------------------------------------------------------
  val_t            store_mem [MAX_ITEMS];
  logic [RW-1:0]   stack_mem [MAX_ITEMS];

  logic            mem_we;
  logic [IW-1:0]   mem_wa;
  val_t            mem_wd;
  logic [IW-1:0]   mem_ra;
  val_t            rd_r;

  logic            stk_we;
  logic [IW-1:0]   stk_wa;
  logic [RW-1:0]   stk_wd;
  logic [IW-1:0]   stk_ra;
  logic [RW-1:0]   stk_rd_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_wa] <= mem_wd;
    end
    rd_r <= store_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stack_mem[stk_ra];
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;      // items held
  logic            drop_r, drop_nxt;    // an item was dropped this set
  logic [CW-1:0]   sp_r, sp_nxt;        // stack fill
  logic [CW-1:0]   k_r, k_nxt;          // emit index
  logic [IW-1:0]   lo_r, lo_nxt;
  logic [IW-1:0]   hi_r, hi_nxt;
  sidx_t           l_r, l_nxt;
  sidx_t           r_r, r_nxt;
  val_t            piv_r, piv_nxt;
  val_t            vl_r, vl_nxt;        // value stopped at by left scan
  val_t            vr_r, vr_nxt;        // value stopped at by right scan

  logic            out_valid_r, out_valid_nxt;
  val_t            out_val_r, out_val_nxt;
  logic            out_end_r, out_end_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            out_free;
  logic [CW-1:0]   n_new;
  logic [IW-1:0]   pop_lo, pop_hi, mid;
  sidx_t           lo_s, hi_s;

  assign out_free = !out_valid_r || !out_stall;
  assign lo_s     = $signed({2'b00, lo_r});
  assign hi_s     = $signed({2'b00, hi_r});
  assign pop_lo   = stk_rd_r[IW-1:0];
  assign pop_hi   = stk_rd_r[RW-1:IW];
  // middle index, truncating like (lo + hi) / 2
  assign mid      = IW'(({1'b0, pop_lo} + {1'b0, pop_hi}) >> 1);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    sp_nxt        = sp_r;
    k_nxt         = k_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    piv_nxt       = piv_r;
    vl_nxt        = vl_r;
    vr_nxt        = vr_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_end_nxt   = out_end_r;
    out_ovf_nxt   = out_ovf_r;
    n_new         = cnt_r;

    mem_we = 1'b0;
    mem_wa = l_r[IW-1:0];
    mem_wd = vr_r;
    mem_ra = l_r[IW-1:0];
    stk_we = 1'b0;
    stk_wa = sp_r[IW-1:0];
    stk_wd = {hi_r, l_r[IW-1:0]};
    stk_ra = sp_r[IW-1:0];

    // output register drains on an accepted beat
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            mem_we = 1'b1;
            mem_wa = cnt_r[IW-1:0];
            mem_wd = in_item_value;
            n_new  = CW'(cnt_r + 1'b1);
          end else begin
            drop_nxt = 1'b1;
          end
          cnt_nxt = n_new;
          if (in_last_item) begin
            k_nxt = '0;
            if (n_new < CW'(2)) begin
              state_nxt = ST_EMREQ;
            end else begin
              // whole set is the first range
              stk_we    = 1'b1;
              stk_wa    = '0;
              stk_wd    = {IW'(n_new - 1'b1), IW'(0)};
              sp_nxt    = CW'(1);
              state_nxt = ST_POP;
            end
          end
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          k_nxt     = '0;
          state_nxt = ST_EMREQ;
        end else begin
          stk_ra    = IW'(sp_r - 1'b1);
          sp_nxt    = CW'(sp_r - 1'b1);
          state_nxt = ST_PIVA;
        end
      end
      ST_PIVA: begin
        lo_nxt    = pop_lo;
        hi_nxt    = pop_hi;
        l_nxt     = $signed({2'b00, pop_lo});
        r_nxt     = $signed({2'b00, pop_hi});
        mem_ra    = mid;
        state_nxt = ST_PIVB;
      end
      ST_PIVB: begin
        piv_nxt   = rd_r;
        state_nxt = ST_SLREQ;
      end
      ST_SLREQ: begin
        mem_ra = l_r[IW-1:0];
        if (l_r > hi_s) begin
          state_nxt = ST_SRREQ;
        end else begin
          state_nxt = ST_SLCHK;
        end
      end
      ST_SLCHK: begin
        if (rd_r < piv_r) begin
          l_nxt     = SW'(l_r + 1);
          state_nxt = ST_SLREQ;
        end else begin
          vl_nxt    = rd_r;
          state_nxt = ST_SRREQ;
        end
      end
      ST_SRREQ: begin
        mem_ra = r_r[IW-1:0];
        if (r_r < lo_s) begin
          state_nxt = ST_SWAP1;
        end else begin
          state_nxt = ST_SRCHK;
        end
      end
      ST_SRCHK: begin
        if (rd_r > piv_r) begin
          r_nxt     = SW'(r_r - 1);
          state_nxt = ST_SRREQ;
        end else begin
          vr_nxt    = rd_r;
          state_nxt = ST_SWAP1;
        end
      end
      ST_SWAP1: begin
        if (l_r <= r_r) begin
          mem_we    = 1'b1;
          mem_wa    = l_r[IW-1:0];
          mem_wd    = vr_r;
          state_nxt = ST_SWAP2;
        end else begin
          state_nxt = ST_PUSHLO;
        end
      end
      ST_SWAP2: begin
        mem_we    = 1'b1;
        mem_wa    = r_r[IW-1:0];
        mem_wd    = vl_r;
        l_nxt     = SW'(l_r + 1);
        r_nxt     = SW'(r_r - 1);
        state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (l_r <= r_r) begin
          state_nxt = ST_SLREQ;
        end else begin
          state_nxt = ST_PUSHLO;
        end
      end
      ST_PUSHLO: begin
        if (lo_s < r_r && sp_r < CW'(MAX_ITEMS)) begin
          stk_we = 1'b1;
          stk_wa = sp_r[IW-1:0];
          stk_wd = {r_r[IW-1:0], lo_r};
          sp_nxt = CW'(sp_r + 1'b1);
        end
        state_nxt = ST_PUSHHI;
      end
      ST_PUSHHI: begin
        if (hi_s > l_r && sp_r < CW'(MAX_ITEMS)) begin
          stk_we = 1'b1;
          stk_wa = sp_r[IW-1:0];
          stk_wd = {hi_r, l_r[IW-1:0]};
          sp_nxt = CW'(sp_r + 1'b1);
        end
        state_nxt = ST_POP;
      end
      ST_EMREQ: begin
        mem_ra    = k_r[IW-1:0];
        state_nxt = ST_EMWAIT;
      end
      ST_EMWAIT: begin
        // keep the address so rd_r holds store[k] while the output is stalled
        mem_ra = k_r[IW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = rd_r;
          out_end_nxt   = (k_r == CW'(cnt_r - 1'b1));
          out_ovf_nxt   = drop_r;
          if (k_r == CW'(cnt_r - 1'b1)) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = CW'(k_r + 1'b1);
            state_nxt = ST_EMREQ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      sp_r        <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      sp_r        <= sp_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    piv_r     <= piv_nxt;
    vl_r      <= vl_nxt;
    vr_r      <= vr_nxt;
    out_val_r <= out_val_nxt;
    out_end_r <= out_end_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_val_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflow     = out_ovf_r;

endmodule

// ----- rtl/qmp_checker.sv -----
`timescale 1ns / 1ps
// qmp_checker: port-level assertions for quicksort_middle_pivot, plus its bind.
// Depends on qmp_pkg.
module qmp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [qmp_pkg::VAL_W-1:0] out_sorted_value,
  input logic                             out_end_of_run,
  input logic                             out_overflow
);

  logic                             in_run_r;   // run beats accepted, end not yet seen
  logic signed [qmp_pkg::VAL_W-1:0] prev_val_r;
  logic                             prev_ovf_r;
  logic                             out_beat;

  assign out_beat = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_run_r <= 1'b0;
    end else if (out_beat) begin
      in_run_r <= !out_end_of_run;
    end
    if (out_beat) begin
      prev_val_r <= out_sorted_value;
      prev_ovf_r <= out_overflow;
    end
  end

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sorted_value)
      && $stable(out_end_of_run) && $stable(out_overflow))
    else $error("result beat changed under stall");

  // run comes out ascending
  a_ascending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_run_r |-> out_sorted_value >= prev_val_r)
    else $error("sorted run out of order");

  // overflow flag is the same on every beat of a run
  a_ovf_const: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && in_run_r |-> out_overflow == prev_ovf_r)
    else $error("overflow flag changed within a run");

  // no new set is taken until the end beat of the run sits in the output register
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r && !(out_valid && out_end_of_run) |-> in_stall)
    else $error("input accepted in the middle of a run");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind quicksort_middle_pivot qmp_checker u_qmp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sorted_value (out_sorted_value),
  .out_end_of_run   (out_end_of_run),
  .out_overflow     (out_overflow)
);

// ----- test/quicksort_middle_pivot_tb.sv -----
`timescale 1ns / 1ps
// Testbench for quicksort_middle_pivot: loads sets of signed items, predicts each sorted run
// with its own quicksort model and checks every result beat. Depends on rtl/qmp_pkg.sv.
module quicksort_middle_pivot_tb;

  localparam int CLK_PERIOD      = 8;
  localparam int DEPTH           = qmp_pkg::MAX_ITEMS_DEF;
  localparam int RESET_CYCLES    = 9;
  // Idle time without any accepted beat beyond this limit means the block is hung.
  localparam int WATCHDOG_LIMIT  = 60000;
  localparam int HOLD_OFF_CYCLES = 4000;  // long receiver stall for the fill-up test
  localparam int SETTLE_CYCLES   = 200;   // quiet time after the last result
  localparam int RANDOM_ITEMS    = 180;
  localparam int MAX_REPORTS     = 10;

  typedef enum int {VALS_ANY, VALS_NARROW, VALS_EDGES} value_mix_t;

  typedef struct packed {
    logic signed [qmp_pkg::VAL_W-1:0] value;
    logic                             end_of_run;
    logic                             overflow;
  } sorted_beat_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [qmp_pkg::VAL_W-1:0] in_item_value;
  logic in_last_item;
  logic out_valid;
  logic out_stall;
  logic signed [qmp_pkg::VAL_W-1:0] out_sorted_value;
  logic out_end_of_run;
  logic out_overflow;

  // Predictor state: the set being loaded and whether anything was dropped from it.
  logic signed [qmp_pkg::VAL_W-1:0] held_values [0:DEPTH-1];
  int   held_count;
  logic held_dropped;

  sorted_beat_t sorted_beats_due[$];   // predicted beats, oldest first

  int  mismatches;
  int  idle_cycles;
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  int  rx_hold;        // cycles of forced receiver stall, counted down by the stall process
  int  rx_stall_run;

  always #(CLK_PERIOD / 2) clk = ~clk;

  quicksort_middle_pivot #(
    .MAX_ITEMS(DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item_value   (in_item_value),
    .in_last_item    (in_last_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sorted_value(out_sorted_value),
    .out_end_of_run  (out_end_of_run),
    .out_overflow    (out_overflow)
  );

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Quicksort of the held set, Hoare partition around the middle element, pending ranges
  // kept on an explicit stack. Bounds are tested before the store is read, so an index of
  // -1 or DEPTH is never dereferenced.
  function automatic void quicksort_held(int count);
    int lo_stk [DEPTH];
    int hi_stk [DEPTH];
    int top;
    int lo;
    int hi;
    int l;
    int r;
    logic signed [qmp_pkg::VAL_W-1:0] piv;
    logic signed [qmp_pkg::VAL_W-1:0] tmp;
    if (count < 2) return;
    lo_stk[0] = 0;
    hi_stk[0] = count - 1;
    top = 1;
    while (top > 0) begin
      top--;
      lo  = lo_stk[top];
      hi  = hi_stk[top];
      l   = lo;
      r   = hi;
      piv = held_values[(lo + hi) / 2];
      while (l <= r) begin
        while (l <= hi && held_values[l] < piv) l++;
        while (r >= lo && held_values[r] > piv) r--;
        if (l <= r) begin
          tmp            = held_values[l];
          held_values[l] = held_values[r];
          held_values[r] = tmp;
          l++;
          r--;
        end
      end
      if (lo < r && top < DEPTH) begin
        lo_stk[top] = lo;
        hi_stk[top] = r;
        top++;
      end
      if (hi > l && top < DEPTH) begin
        lo_stk[top] = l;
        hi_stk[top] = hi;
        top++;
      end
    end
  endfunction

  // Account for one accepted input beat; a flagged last beat closes the set and queues
  // the whole sorted run. A full store drops the item, the last one included.
  function automatic void load_item(logic signed [qmp_pkg::VAL_W-1:0] value, logic last);
    sorted_beat_t beat;
    if (held_count < DEPTH) begin
      held_values[held_count] = value;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (last) begin
      quicksort_held(held_count);
      for (int k = 0; k < held_count; k++) begin
        beat.value      = held_values[k];
        beat.end_of_run = (k == held_count - 1);
        beat.overflow   = held_dropped;
        sorted_beats_due.push_back(beat);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------------------

  // Mostly back-to-back, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [qmp_pkg::VAL_W-1:0] pick_value(value_mix_t mix);
    case (mix)
      VALS_NARROW: return $signed($urandom_range(0, 7)) - 4;   // heavy on duplicates
      VALS_EDGES: begin
        case ($urandom_range(0, 5))
          0:       return 32'sh8000_0000;
          1:       return 32'sh8000_0001;
          2:       return 32'sh7fff_ffff;
          3:       return 32'sh7fff_fffe;
          4:       return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic value_mix_t pick_mix();
    case ($urandom_range(0, 5))
      0:       return VALS_NARROW;
      1:       return VALS_EDGES;
      default: return VALS_ANY;
    endcase
  endfunction

  // Small sets dominate; a few reach the full store.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 94) return $urandom_range(9, 32);
    return $urandom_range(33, DEPTH);
  endfunction

  // ---------------------------------------------------------------------------------------
  // Input side: one beat per call. Drives at the falling edge, waits for the accepting
  // rising edge. With no gap, valid simply stays high for the next beat.
  // ---------------------------------------------------------------------------------------
  task automatic send_beat(input logic signed [qmp_pkg::VAL_W-1:0] value, input logic last);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_item_value <= value;
    in_last_item  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    load_item(value, last);
  endtask

  task automatic send_set(input int size, input value_mix_t mix);
    for (int i = 0; i < size; i++) send_beat(pick_value(mix), i == size - 1);
  endtask

  task automatic release_input();
    @(negedge clk) in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sorted_beats_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------------------

  // Stall driver: a forced hold-off wins, otherwise random stall runs when enabled.
  initial begin
    out_stall    = 1'b0;
    rx_stall_run = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        if (rx_stall_run == 0 && rx_gaps_on) rx_stall_run = pick_gap();
        if (rx_stall_run > 0) begin
          out_stall <= 1'b1;
          rx_stall_run--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Result checker: every accepted beat is matched against the oldest prediction.
  always @(posedge clk) begin
    sorted_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_beats_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected beat: value %0d end %0b ovf %0b",
                   out_sorted_value, out_end_of_run, out_overflow);
      end else begin
        want = sorted_beats_due.pop_front();
        if (out_sorted_value !== want.value || out_end_of_run !== want.end_of_run ||
            out_overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want value %0d end %0b ovf %0b, got value %0d end %0b ovf %0b",
                     want.value, want.end_of_run, want.overflow,
                     out_sorted_value, out_end_of_run, out_overflow);
        end
      end
    end
  end

  // Watchdog: any accepted beat on either side resets the idle count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // One-item sets: each run is its item alone, flagged end of run.
  task automatic test_single_item();
    send_beat(32'sh8000_0000, 1'b1);
    send_beat(32'sd17, 1'b1);
  endtask

  // Full-scale values out of order, to catch unsigned compares.
  task automatic test_extremes();
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(-32'sd1,        1'b0);
    send_beat(32'sh8000_0001, 1'b0);
    send_beat(32'sh7fff_fffe, 1'b1);
  endtask

  // All-equal keys, presorted and reverse-sorted input: the partition corner cases.
  task automatic test_ordered_and_equal();
    for (int i = 0; i < 5; i++) send_beat(-32'sd5, i == 4);
    for (int i = 0; i < 5; i++) send_beat(i * 3 - 6, i == 4);
    for (int i = 0; i < 5; i++) send_beat(1000 - i * 250, i == 4);
  endtask

  // Store full: exactly full, then one over so the flagged last item itself is dropped,
  // then a small set to see the dropped flag clear after the run.
  task automatic test_full_store();
    send_set(DEPTH, VALS_ANY);
    send_set(DEPTH + 1, pick_mix());
    send_set(3, VALS_ANY);
  endtask

  task automatic test_random_sets();
    int sent;
    int size;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      size = pick_set_size();
      send_set(size, pick_mix());
      sent += size;
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering: the block must
  // finish its set, fill its output and push back on the next set's first beat.
  task automatic test_output_hold_off();
    @(posedge clk) rx_hold = HOLD_OFF_CYCLES;
    send_set(40, VALS_ANY);
    send_set(10, VALS_NARROW);
  endtask

  // Sender goes quiet until every result is back, then resumes.
  task automatic test_sender_pause();
    send_set(6, VALS_ANY);
    release_input();
    wait_drained();
    send_set(5, VALS_EDGES);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_item_value = '0;
    in_last_item  = 1'b0;
    held_count    = 0;
    held_dropped  = 1'b0;
    mismatches    = 0;
    tx_gaps_on    = 1'b0;
    rx_gaps_on    = 1'b0;
    rx_hold       = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed part runs back to back on both sides
    test_single_item();
    test_extremes();
    test_ordered_and_equal();

    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    test_full_store();
    test_random_sets();
    test_output_hold_off();
    test_sender_pause();

    release_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && sorted_beats_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (sorted_beats_due.size() != 0)
        $display("%0d predicted beats never arrived", sorted_beats_due.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/qmp_pkg.sv
rtl/quicksort_middle_pivot.sv
rtl/qmp_checker.sv
test/quicksort_middle_pivot_tb.sv
